// ===== design/swts_pkg.sv =====
`default_nettype none

package swts_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LEN_BITS        = 7;
	localparam int TOTAL_BITS      = 64;
	localparam int PDATA_BITS      = 32;
	localparam int PADDR_BITS      = 3;

	localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd8;

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_INSERT = 2'd3
	} cell_op_t;

endpackage

`default_nettype wire

// ===== design/swts_ram.sv =====
`default_nettype none

module swts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/swts_cell.sv =====
`default_nettype none

module swts_cell #(
	parameter int SAMPLE_BITS = swts_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire swts_pkg::cell_op_t            op,
	input  wire logic signed [SAMPLE_BITS-1:0] key,
	input  wire logic signed [SAMPLE_BITS-1:0] left_val,
	input  wire logic                          left_valid,
	input  wire logic                          left_gt,
	input  wire logic signed [SAMPLE_BITS-1:0] right_val,
	input  wire logic                          right_valid,
	output logic signed [SAMPLE_BITS-1:0]      val,
	output logic                               valid,
	output logic                               gt
);

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic                          valid_q;
	logic                          shift_down;

	// empty cells count as larger than any key
	assign gt         = !valid_q || (val_q > key);
	assign shift_down = valid_q && (val_q >= key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				swts_pkg::OP_CLEAR: begin
					valid_q <= 1'b0;
				end
				swts_pkg::OP_REMOVE: begin
					if (shift_down) begin
						valid_q <= right_valid;
					end
				end
				swts_pkg::OP_INSERT: begin
					if (gt && !left_gt) begin
						valid_q <= 1'b1;
					end else if (gt) begin
						valid_q <= left_valid;
					end
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			swts_pkg::OP_REMOVE: begin
				if (shift_down) begin
					val_q <= right_val;
				end
			end
			swts_pkg::OP_INSERT: begin
				if (gt && !left_gt) begin
					val_q <= key;
				end else if (gt) begin
					val_q <= left_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign val   = val_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ===== design/swts_sorter.sv =====
`default_nettype none

module swts_sorter #(
	parameter int SAMPLE_BITS = swts_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_WINDOW  = swts_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire swts_pkg::cell_op_t            op,
	input  wire logic signed [SAMPLE_BITS-1:0] key,
	output logic signed [SAMPLE_BITS-1:0]      lo,
	output logic signed [SAMPLE_BITS-1:0]      hi
);

	logic signed [SAMPLE_BITS-1:0] val    [MAX_WINDOW];
	logic                          valid  [MAX_WINDOW];
	logic                          gt     [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] lval   [MAX_WINDOW];
	logic                          lvalid [MAX_WINDOW];
	logic                          lgt    [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rval   [MAX_WINDOW];
	logic                          rvalid [MAX_WINDOW];
	logic                          top    [MAX_WINDOW];

	// cells hold the window in ascending order, filled from cell 0 up
	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		if (k == 0) begin : g_first
			assign lval[k]   = '0;
			assign lvalid[k] = 1'b0;
			assign lgt[k]    = 1'b0;
		end else begin : g_inner_l
			assign lval[k]   = val[k-1];
			assign lvalid[k] = valid[k-1];
			assign lgt[k]    = gt[k-1];
		end
		if (k == MAX_WINDOW - 1) begin : g_last
			assign rval[k]   = '0;
			assign rvalid[k] = 1'b0;
		end else begin : g_inner_r
			assign rval[k]   = val[k+1];
			assign rvalid[k] = valid[k+1];
		end
		assign top[k] = valid[k] && !rvalid[k];

		swts_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.key        (key),
			.left_val   (lval[k]),
			.left_valid (lvalid[k]),
			.left_gt    (lgt[k]),
			.right_val  (rval[k]),
			.right_valid(rvalid[k]),
			.val        (val[k]),
			.valid      (valid[k]),
			.gt         (gt[k])
		);
	end

	assign lo = val[0];

	// at most one cell is the top of the occupied run; hi is zero when none is
	always_comb begin
		hi = '0;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (top[k]) begin
				hi = hi | val[k];
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/sliding_window_trimmed_sum.sv =====
// channel  | direction | handshake           | payload
// in       | input     | in_valid / in_stall  | sample, restart
// out      | output    | out_valid / out_stall| trimmed_sum, window_min, window_max,
//          |           |                     | running_total
// cfg      | input     | APB write, pready=1 | window_len at byte address 0
//
// Once the window gives a result, an item takes these steps: read of the oldest
// sample from the delay RAM, a removal pass and an insertion pass through the
// sorted cell row, trim, then the output load; while the window fills, it stops after the insertion pass.
// The output register lets the next item enter while a result waits; a
// result stalled at the output holds the item behind it in its last step.
// Reset empties the cell row, the sum, counters and the total; the delay RAM
// is not cleared and needs no clearing pass.
`default_nettype none

module sliding_window_trimmed_sum #(
	parameter int MAX_WINDOW  = swts_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swts_pkg::SAMPLE_BITS_DEF,
	localparam int TRIM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]          sample,
	input  wire logic                                   restart,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [TRIM_BITS-1:0]                 trimmed_sum,
	output logic signed [SAMPLE_BITS-1:0]               window_min,
	output logic signed [SAMPLE_BITS-1:0]               window_max,
	output logic signed [swts_pkg::TOTAL_BITS-1:0]      running_total,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [swts_pkg::PADDR_BITS-1:0]        paddr,
	input  wire logic [swts_pkg::PDATA_BITS-1:0]        pwdata,
	output logic      [swts_pkg::PDATA_BITS-1:0]        prdata,
	output logic                                        pready
);

	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int TB = TRIM_BITS;
	localparam int SB = SAMPLE_BITS;
	localparam int XB = swts_pkg::TOTAL_BITS;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REMOVE = 5'b00010,
		ST_INSERT = 5'b00100,
		ST_TRIM   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t                            state_q;
	logic [swts_pkg::LEN_BITS-1:0]     len_q;
	logic [LW-1:0]                     len_eff;
	logic [31:0]                       len_wide;
	logic [LW-1:0]                     fill_q;
	logic [PW-1:0]                     ptr_q;
	logic [PW-1:0]                     ram_addr;
	logic signed [TB-1:0]              sum_q;
	logic signed [XB-1:0]              total_q;
	logic signed [XB-1:0]              total_next;
	logic signed [SB-1:0]              x_q;
	logic signed [SB-1:0]              old_val;
	logic signed [SB-1:0]              lo;
	logic signed [SB-1:0]              hi;
	logic signed [SB-1:0]              lo_q;
	logic signed [SB-1:0]              hi_q;
	logic signed [TB-1:0]              trim_q;
	logic signed [TB-1:0]              old_ext;
	logic signed [TB-1:0]              x_ext;
	logic                              in_accept;
	logic                              cfg_wr;
	logic                              full;
	logic                              out_load;
	logic                              out_valid_q;
	logic signed [TB-1:0]              trim_out_q;
	logic signed [SB-1:0]              min_out_q;
	logic signed [SB-1:0]              max_out_q;
	logic signed [XB-1:0]              total_out_q;
	logic [PW-1:0]                     ptr_next;
	swts_pkg::cell_op_t                cell_op;
	logic signed [SB-1:0]              cell_key;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[swts_pkg::PADDR_BITS-1] == swts_pkg::REG_WINDOW_LEN);
	assign prdata = (paddr[swts_pkg::PADDR_BITS-1] == swts_pkg::REG_WINDOW_LEN) ?
		swts_pkg::PDATA_BITS'(len_q) : '0;

	assign len_wide = 32'(len_q);

	always_comb begin
		priority if (len_q == '0) begin
			len_eff = LW'(1);
		end else if (len_wide > 32'(MAX_WINDOW)) begin
			len_eff = LW'(MAX_WINDOW);
		end else begin
			len_eff = LW'(len_wide);
		end
	end

	assign full     = (fill_q >= len_eff);
	assign ptr_next = ((32'(ptr_q) + 32'd1) >= 32'(len_eff)) ? '0 : PW'(32'(ptr_q) + 32'd1);
	assign ram_addr = restart ? '0 : ptr_q;

	// old sample comes back registered, in the cycle after the request is taken, for the removal step
	swts_ram #(
		.WIDTH(SB),
		.DEPTH(MAX_WINDOW)
	) u_delay (
		.clk  (clk),
		.we   (in_accept),
		.waddr(ram_addr),
		.wdata(sample),
		.raddr(ram_addr),
		.rdata(old_val)
	);

	assign old_ext = {{(TB - SB){old_val[SB-1]}}, old_val};
	assign x_ext   = {{(TB - SB){x_q[SB-1]}}, x_q};

	always_comb begin
		cell_op  = swts_pkg::OP_HOLD;
		cell_key = x_q;
		if (cfg_wr || (in_accept && restart)) begin
			cell_op = swts_pkg::OP_CLEAR;
		end else if ((state_q == ST_REMOVE) && full) begin
			cell_op  = swts_pkg::OP_REMOVE;
			cell_key = old_val;
		end else if (state_q == ST_INSERT) begin
			cell_op = swts_pkg::OP_INSERT;
		end
	end

	swts_sorter #(
		.SAMPLE_BITS(SB),
		.MAX_WINDOW (MAX_WINDOW)
	) u_sorter (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (cell_op),
		.key   (cell_key),
		.lo    (lo),
		.hi    (hi)
	);

	assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign total_next = total_q + {{(XB - TB){trim_q[TB-1]}}, trim_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= swts_pkg::LEN_RESET;
			fill_q      <= '0;
			ptr_q       <= '0;
			sum_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				len_q   <= pwdata[swts_pkg::LEN_BITS-1:0];
				fill_q  <= '0;
				ptr_q   <= '0;
				sum_q   <= '0;
				total_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (restart) begin
							fill_q  <= '0;
							ptr_q   <= '0;
							sum_q   <= '0;
							total_q <= '0;
						end
						state_q <= ST_REMOVE;
					end
				end
				ST_REMOVE: begin
					if (full) begin
						sum_q <= sum_q - old_ext;
					end else begin
						fill_q <= fill_q + LW'(1);
					end
					ptr_q   <= ptr_next;
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					sum_q   <= sum_q + x_ext;
					state_q <= full ? ST_TRIM : ST_IDLE;
				end
				ST_TRIM: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						total_q <= total_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample;
		end
		if (state_q == ST_TRIM) begin
			trim_q <= sum_q - TB'(lo) - TB'(hi);
			lo_q   <= lo;
			hi_q   <= hi;
		end
		if (out_load) begin
			trim_out_q  <= trim_q;
			min_out_q   <= lo_q;
			max_out_q   <= hi_q;
			total_out_q <= total_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign trimmed_sum   = trim_out_q;
	assign window_min    = min_out_q;
	assign window_max    = max_out_q;
	assign running_total = total_out_q;

endmodule

`default_nettype wire

// ===== design/swts_chk.sv =====
`default_nettype none

module swts_chk #(
	parameter int SAMPLE_BITS = swts_pkg::SAMPLE_BITS_DEF,
	parameter int TRIM_BITS   = 23
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [TRIM_BITS-1:0]          trimmed_sum,
	input wire logic signed [SAMPLE_BITS-1:0]        window_min,
	input wire logic signed [SAMPLE_BITS-1:0]        window_max,
	input wire logic signed [swts_pkg::TOTAL_BITS-1:0] running_total
);

	// one request in flight: the input closes right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request was taken");

	// a fresh result is only loaded from the final step of an item
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

	// with the input open there is no result pending to reload the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("result repeated after it was taken");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_min <= window_max))
		else $error("window minimum above maximum");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(trimmed_sum) &&
		$stable(running_total))
		else $error("stalled result changed");

endmodule

bind sliding_window_trimmed_sum swts_chk #(
	.SAMPLE_BITS(SAMPLE_BITS),
	.TRIM_BITS  (TRIM_BITS)
) u_swts_chk (.*);

`default_nettype wire
